// ===== hw/rtl/mcbp_pkg.sv =====
// shared types and codes for the multi-channel byte pipe fifo
// no dependencies; imported by the top level and the checker
package mcbp_pkg;

    localparam int CMD_W       = 2;
    localparam int ID_W        = 3;
    localparam int BYTE_W      = 8;
    localparam int REQ_W       = 9;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_OPEN  = 2'd0;
    localparam t_cmd CMD_WRITE = 2'd1;
    localparam t_cmd CMD_DONE  = 2'd2;
    localparam t_cmd CMD_READ  = 2'd3;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_NOT_OPEN = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_EMPTY    = 3'd3;
    localparam t_status ST_END      = 3'd4;
    localparam t_status ST_NO_SLOT  = 3'd5;

endpackage

// ===== hw/rtl/mcbp_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module mcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/multi_channel_byte_pipe_fifo.sv =====
// multi-channel byte pipe fifo: per-pipe circular buffers in one shared byte ram
// depends on mcbp_pkg and mcbp_ram
// a result passes the pointer ram read (S_META) and S_OUT; a read that returns
//   a byte also passes the byte ram read (S_DATA); one item is in flight, so a
//   new item waits until the last result is loaded into the output register
// reset (sync, active low): slots free, done marks clear, no result pending
module multi_channel_byte_pipe_fifo #(
    parameter int PIPES = 8,
    parameter int DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // pipe_id [2:0], data_byte [10:3], open_size [19:11], zero [23:20]
    input  logic [mcbp_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // command [1:0]
    input  logic [mcbp_pkg::CMD_W-1:0]        i_s_tuser,
    // result items
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // slot_out [2:0], data_out [10:3], zero [15:11]
    output logic [mcbp_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // status [2:0]
    output logic [mcbp_pkg::STATUS_W-1:0]     o_m_tuser
);

    import mcbp_pkg::*;

    // index, pointer, size and address widths
    localparam int IW  = (PIPES > 1) ? $clog2(PIPES) : 1;
    localparam int PW  = $clog2(DEPTH);
    localparam int SW  = $clog2(DEPTH + 1);
    localparam int MW  = SW + 2 * PW;
    localparam int BAW = $clog2(PIPES * DEPTH);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;   // waiting for an item
    localparam logic [1:0] S_META = 2'd1;   // pointer ram data valid, decide
    localparam logic [1:0] S_DATA = 2'd2;   // byte ram data valid
    localparam logic [1:0] S_OUT  = 2'd3;   // hand result to output register

    logic [1:0]        r_state, n_state;
    t_cmd              r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [BYTE_W-1:0] r_byte;
    logic [REQ_W-1:0]  r_req;
    logic              r_free_ok;
    logic [IW-1:0]     r_free_idx;
    logic [PIPES-1:0]  r_open, n_open;
    logic [PIPES-1:0]  r_done, n_done;
    t_status           r_status, n_status;
    logic [ID_W-1:0]   r_slot, n_slot;
    logic [BYTE_W-1:0] r_data, n_data;

    // output register
    logic              r_m_valid;
    t_status           r_m_status;
    logic [ID_W-1:0]   r_m_slot;
    logic [BYTE_W-1:0] r_m_data;

    // input field split
    logic [ID_W-1:0]   in_id;
    logic [BYTE_W-1:0] in_byte;
    logic [REQ_W-1:0]  in_req;
    logic              s_accept;
    logic              out_load;

    // lowest free slot search
    logic              free_ok;
    logic [IW-1:0]     free_idx;

    // pointer ram: {size, write pointer, read pointer}
    logic              meta_we;
    logic [IW-1:0]     meta_waddr;
    logic [MW-1:0]     meta_wdata;
    logic [MW-1:0]     meta_rd;
    logic [PW-1:0]     m_rp, m_wp, rp_nx, wp_nx;
    logic [SW-1:0]     m_sz, open_sz;

    // byte ram
    logic              byte_we;
    logic [BAW-1:0]    byte_waddr, byte_raddr;
    logic [BYTE_W-1:0] byte_rd;

    logic [IW-1:0]     id_idx;
    logic              id_ok;

    function automatic logic [PW-1:0] f_advance(input logic [PW-1:0] ptr,
                                               input logic [SW-1:0] size);
        logic [SW-1:0] inc;
        inc = SW'(ptr) + SW'(1);
        return (inc >= size) ? {PW{1'b0}} : PW'(inc);
    endfunction

    assign in_id   = i_s_tdata[2:0];
    assign in_byte = i_s_tdata[10:3];
    assign in_req  = i_s_tdata[19:11];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == S_OUT) && (!r_m_valid || i_m_tready);

    // priority search, lowest index wins
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = PIPES - 1; i >= 0; i--) begin
            if (!r_open[i]) begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign id_idx = IW'(r_id);
    assign id_ok  = (int'(r_id) < PIPES) && r_open[id_idx];

    assign m_rp  = meta_rd[PW-1:0];
    assign m_wp  = meta_rd[2*PW-1:PW];
    assign m_sz  = meta_rd[MW-1:2*PW];
    assign rp_nx = f_advance(m_rp, m_sz);
    assign wp_nx = f_advance(m_wp, m_sz);

    // size zero becomes one, oversize saturates at DEPTH
    assign open_sz = (r_req == '0)           ? SW'(1) :
                     (int'(r_req) > DEPTH)   ? SW'(DEPTH) : SW'(r_req);

    // each pipe owns a DEPTH-byte region of the byte ram
    assign byte_waddr = BAW'(id_idx) * BAW'(DEPTH) + BAW'(m_wp);
    assign byte_raddr = BAW'(id_idx) * BAW'(DEPTH) + BAW'(m_rp);

    always_comb begin
        n_state    = r_state;
        n_open     = r_open;
        n_done     = r_done;
        n_status   = r_status;
        n_slot     = r_slot;
        n_data     = r_data;
        meta_we    = 1'b0;
        meta_waddr = id_idx;
        meta_wdata = meta_rd;
        byte_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_META;
                end
            end
            S_META: begin
                n_slot  = '0;
                n_data  = '0;
                n_state = S_OUT;
                if (r_cmd == CMD_OPEN) begin
                    if (r_free_ok) begin
                        n_status           = ST_OK;
                        n_slot             = ID_W'(r_free_idx);
                        n_open[r_free_idx] = 1'b1;
                        n_done[r_free_idx] = 1'b0;
                        meta_we            = 1'b1;
                        meta_waddr         = r_free_idx;
                        meta_wdata         = {open_sz, {PW{1'b0}}, {PW{1'b0}}};
                    end else begin
                        n_status = ST_NO_SLOT;
                    end
                end else if (!id_ok) begin
                    n_status = ST_NOT_OPEN;
                end else begin
                    case (r_cmd)
                        CMD_WRITE: begin
                            if (wp_nx == m_rp) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status   = ST_OK;
                                byte_we    = 1'b1;
                                meta_we    = 1'b1;
                                meta_wdata = {m_sz, wp_nx, m_rp};
                            end
                        end
                        CMD_DONE: begin
                            n_status       = ST_OK;
                            n_done[id_idx] = 1'b1;
                        end
                        CMD_READ: begin
                            if (m_rp == m_wp) begin
                                if (r_done[id_idx]) begin
                                    // drained and finished: release the slot
                                    n_status       = ST_END;
                                    n_open[id_idx] = 1'b0;
                                    n_done[id_idx] = 1'b0;
                                end else begin
                                    n_status = ST_EMPTY;
                                end
                            end else begin
                                n_status   = ST_OK;
                                meta_we    = 1'b1;
                                meta_wdata = {m_sz, m_wp, rp_nx};
                                n_state    = S_DATA;
                            end
                        end
                        default: begin
                            n_status = ST_NOT_OPEN;
                        end
                    endcase
                end
            end
            S_DATA: begin
                n_data  = byte_rd;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_open    <= '0;
            r_done    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_done  <= n_done;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd      <= i_s_tuser;
            r_id       <= in_id;
            r_byte     <= in_byte;
            r_req      <= in_req;
            r_free_ok  <= free_ok;
            r_free_idx <= free_idx;
        end
        r_status <= n_status;
        r_slot   <= n_slot;
        r_data   <= n_data;
        if (out_load) begin
            r_m_status <= r_status;
            r_m_slot   <= r_slot;
            r_m_data   <= r_data;
        end
    end

    // per-pipe pointers and size, read on accept
    mcbp_ram #(
        .WIDTH (MW),
        .DEPTH (PIPES)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (IW'(in_id)),
        .o_rdata (meta_rd)
    );

    // shared byte store
    mcbp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PIPES * DEPTH)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (r_byte),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rd)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_status;
    assign o_m_tdata  = {5'b0, r_m_data, r_m_slot};

endmodule

// ===== hw/rtl/mcbp_chk.sv =====
// port-level checker for the multi-channel byte pipe fifo, bound to the top level
// depends on mcbp_pkg
module mcbp_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [mcbp_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [mcbp_pkg::STATUS_W-1:0]    o_m_tuser
);

    import mcbp_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // nothing pending right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // one item in flight: an accept closes the input side for the next cycle
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item accepted back to back");

    // slot and byte are zero unless the status is ok
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_OK |-> o_m_tdata == '0)
        else $error("payload not cleared on error status");

    // status stays within the defined codes
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser != 3'd6 && o_m_tuser != 3'd7)
        else $error("undefined status code");

endmodule

bind multi_channel_byte_pipe_fifo mcbp_chk u_mcbp_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
